// ===== src/trsb_pkg.sv =====
// Package: shared constants and types for the track ring shape blender.
`default_nettype none
package trsb_pkg;

  localparam int TRACKS    = 22;
  localparam int RING_LEN  = 256;
  localparam int CURVES    = 16;
  localparam int CURVE_LEN = 32;

  localparam int TRACK_DEPTH = TRACKS * RING_LEN;
  localparam int CURVE_DEPTH = CURVES * CURVE_LEN;
  localparam int TRACK_IW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int POS_W       = 8;
  localparam int TRACK_AW    = TRACK_IW + POS_W;
  localparam int CURVE_AW    = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
  localparam int IDX_W       = $clog2(CURVE_LEN + 1);
  localparam int CNT_W       = 9;
  localparam int MAX_STEPS   = RING_LEN;
  localparam int CLR_LEN     = (TRACK_DEPTH > CURVE_DEPTH) ? TRACK_DEPTH : CURVE_DEPTH;
  localparam int CLR_W       = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_FILL    = 3'd2;
  localparam logic [2:0] REQ_BLEND_F = 3'd3;
  localparam logic [2:0] REQ_BLEND_B = 3'd4;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_RD    = 6'b001000,
    ST_WR    = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// ===== src/trsb_req_if.sv =====
// Interface: request channel with valid/ready handshake and request fields.
`default_nettype none
interface trsb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [4:0] track_index;
  logic [7:0] position;
  logic [3:0] shape_index;
  logic [8:0] step_count;
  logic [7:0] level;
  logic [4:0] curve_offset;
  logic [7:0] curve_byte;

  modport source (
    output valid, req_type, track_index, position, shape_index, step_count,
           level, curve_offset, curve_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, track_index, position, shape_index, step_count,
           level, curve_offset, curve_byte,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/trsb_res_if.sv =====
// Interface: result channel with valid/ready handshake and result fields.
`default_nettype none
interface trsb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [8:0] bytes_written;

  modport source (output valid, read_byte, bytes_written, input ready);
  modport sink   (input valid, read_byte, bytes_written, output ready);
endinterface
`default_nettype wire

// ===== src/track_ring_shape_blender_core.sv =====
// Top level: track ring and shape curve stores with the request sequencer.
// One request at a time; a blend byte is one track memory read, then the
// write back; a fill byte is a single write. After reset a clearing pass
// zeroes both stores before the first request is accepted.
`default_nettype none
module track_ring_shape_blender_core (
  input wire logic clk,
  input wire logic rst,
  trsb_req_if.sink   req,
  trsb_res_if.source res
);

  trsb_pkg::state_t state;

  logic [trsb_pkg::CLR_W-1:0]    clr;
  logic [2:0]                    kind;
  logic [trsb_pkg::TRACK_IW-1:0] track_r;
  logic [trsb_pkg::POS_W-1:0]    at_r;
  logic [3:0]                    shape_r;
  logic [trsb_pkg::CNT_W-1:0]    nlim;
  logic [trsb_pkg::CNT_W-1:0]    cnt;
  logic [7:0]                    level_r;
  logic                          bwd_r;
  logic [trsb_pkg::IDX_W-1:0]    idx;
  logic                          idx_end;
  logic [7:0]                    rdb;

  logic                          res_valid;
  logic [7:0]                    res_byte;
  logic [trsb_pkg::CNT_W-1:0]    res_cnt;

  logic [7:0] track_mem [0:trsb_pkg::TRACK_DEPTH-1];
  logic [7:0] curve_mem [0:trsb_pkg::CURVE_DEPTH-1];
  logic [7:0] track_q;
  logic [7:0] curve_q;

  logic                          t_we;
  logic [trsb_pkg::TRACK_AW-1:0] t_waddr;
  logic [7:0]                    t_wdata;
  logic [trsb_pkg::TRACK_AW-1:0] t_raddr;
  logic                          c_we;
  logic [trsb_pkg::CURVE_AW-1:0] c_waddr;
  logic [7:0]                    c_wdata;
  logic [trsb_pkg::CURVE_AW-1:0] c_raddr;
  logic [trsb_pkg::IDX_W-1:0]    idx_sel;

  logic                          accept;
  logic                          track_ok;
  logic                          shape_ok;
  logic [trsb_pkg::CNT_W-1:0]    n_sat;
  logic [7:0]                    weight;
  logic [7:0]                    blended;
  logic                          blend_go;
  logic                          res_load;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == trsb_pkg::ST_IDLE);
  assign track_ok = int'(req.track_index) < trsb_pkg::TRACKS;
  assign shape_ok = int'(req.shape_index) < trsb_pkg::CURVES;
  assign n_sat    = (int'(req.step_count) > trsb_pkg::MAX_STEPS) ?
                    trsb_pkg::CNT_W'(trsb_pkg::MAX_STEPS) : req.step_count;

  // Curve positions past the end of the curve read as a zero weight.
  assign weight   = idx_end ? 8'd0 : curve_q;
  assign blend_go = (weight != 8'd0) && (cnt != nlim);
  assign res_load = (state == trsb_pkg::ST_DONE) && (!res_valid || res.ready);

  trsb_blend u_blend (
    .cur_byte (track_q),
    .target   (level_r),
    .weight   (weight),
    .new_byte (blended)
  );

  assign t_raddr = {track_r, at_r};
  assign idx_sel = (int'(idx) < trsb_pkg::CURVE_LEN) ? idx : '0;
  assign c_raddr = trsb_pkg::CURVE_AW'(int'(shape_r) * trsb_pkg::CURVE_LEN + int'(idx_sel));

  always_comb begin
    t_we    = 1'b0;
    t_waddr = {track_r, at_r};
    t_wdata = level_r;
    c_we    = 1'b0;
    c_waddr = trsb_pkg::CURVE_AW'(int'(req.shape_index) * trsb_pkg::CURVE_LEN +
                                  int'(req.curve_offset));
    c_wdata = req.curve_byte;
    case (state)
      trsb_pkg::ST_CLEAR: begin
        t_we    = int'(clr) < trsb_pkg::TRACK_DEPTH;
        t_waddr = trsb_pkg::TRACK_AW'(clr);
        t_wdata = 8'd0;
        c_we    = int'(clr) < trsb_pkg::CURVE_DEPTH;
        c_waddr = trsb_pkg::CURVE_AW'(clr);
        c_wdata = 8'd0;
      end
      trsb_pkg::ST_IDLE: begin
        c_we = accept && (req.req_type == trsb_pkg::REQ_LOAD) && shape_ok &&
               (int'(req.curve_offset) < trsb_pkg::CURVE_LEN);
      end
      trsb_pkg::ST_FILL: begin
        t_we = 1'b1;
      end
      trsb_pkg::ST_WR: begin
        t_we    = (kind != trsb_pkg::REQ_READ) && blend_go;
        t_wdata = blended;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      track_mem[t_waddr] <= t_wdata;
    end
    track_q <= track_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      curve_mem[c_waddr] <= c_wdata;
    end
    curve_q <= curve_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trsb_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      case (state)
        trsb_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == trsb_pkg::CLR_LEN - 1) begin
            state <= trsb_pkg::ST_IDLE;
          end
        end
        trsb_pkg::ST_IDLE: begin
          if (accept) begin
            state <= trsb_pkg::ST_DONE;
            case (req.req_type)
              trsb_pkg::REQ_READ: begin
                if (track_ok) begin
                  state <= trsb_pkg::ST_RD;
                end
              end
              trsb_pkg::REQ_FILL: begin
                if (track_ok && (n_sat != '0)) begin
                  state <= trsb_pkg::ST_FILL;
                end
              end
              trsb_pkg::REQ_BLEND_F, trsb_pkg::REQ_BLEND_B: begin
                if (track_ok && shape_ok) begin
                  state <= trsb_pkg::ST_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        trsb_pkg::ST_FILL: begin
          if (cnt + 1'b1 == nlim) begin
            state <= trsb_pkg::ST_DONE;
          end
        end
        trsb_pkg::ST_RD: begin
          state <= trsb_pkg::ST_WR;
        end
        trsb_pkg::ST_WR: begin
          if ((kind == trsb_pkg::REQ_READ) || !blend_go) begin
            state <= trsb_pkg::ST_DONE;
          end else begin
            state <= trsb_pkg::ST_RD;
          end
        end
        trsb_pkg::ST_DONE: begin
          if (res_load) begin
            state <= trsb_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= trsb_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    case (state)
      trsb_pkg::ST_IDLE: begin
        if (accept) begin
          kind    <= req.req_type;
          track_r <= trsb_pkg::TRACK_IW'(req.track_index);
          shape_r <= req.shape_index;
          nlim    <= n_sat;
          level_r <= req.level;
          bwd_r   <= (req.req_type == trsb_pkg::REQ_BLEND_B);
          cnt     <= '0;
          rdb     <= 8'd0;
          if (req.req_type == trsb_pkg::REQ_BLEND_B) begin
            at_r <= req.position - 1'b1;
            idx  <= trsb_pkg::IDX_W'(1);
          end else begin
            at_r <= req.position;
            idx  <= '0;
          end
        end
      end
      trsb_pkg::ST_FILL: begin
        cnt  <= cnt + 1'b1;
        at_r <= at_r + 1'b1;
      end
      trsb_pkg::ST_RD: begin
        idx_end <= int'(idx) >= trsb_pkg::CURVE_LEN;
      end
      trsb_pkg::ST_WR: begin
        if (kind == trsb_pkg::REQ_READ) begin
          rdb <= track_q;
        end else if (blend_go) begin
          cnt <= cnt + 1'b1;
          idx <= idx + 1'b1;
          if (bwd_r) begin
            at_r <= at_r - 1'b1;
          end else begin
            at_r <= at_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while the next item runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_byte <= rdb;
      res_cnt  <= cnt;
    end
  end

  assign res.valid         = res_valid;
  assign res.read_byte     = res_byte;
  assign res.bytes_written = res_cnt;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == trsb_pkg::ST_FILL) |-> (cnt < nlim))
    else $error("fill ran past its step limit");

  a_blend_idx: assert property (@(posedge clk) disable iff (rst)
    (state == trsb_pkg::ST_WR && kind != trsb_pkg::REQ_READ) |->
      (int'(idx) == int'(cnt) + int'(bwd_r)))
    else $error("blend curve index out of step with write count");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == trsb_pkg::ST_DONE))
    else $error("result raised outside the completion state");

endmodule
`default_nettype wire

// ===== src/trsb_blend.sv =====
// Blend arithmetic: moves one track byte toward a target by a curve weight.
`default_nettype none
module trsb_blend (
  input  wire logic [7:0] cur_byte,
  input  wire logic [7:0] target,
  input  wire logic [7:0] weight,
  output logic      [7:0] new_byte
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;

  // (w << 7) / 2^15 is w / 2^8; bits 15:8 of the product are the floored
  // quotient modulo 256, which is all the wrapped sum needs.
  always_comb begin
    diff     = $signed({1'b0, target}) - $signed({1'b0, cur_byte});
    prod     = diff * $signed({1'b0, weight});
    new_byte = cur_byte + prod[15:8];
  end

endmodule
`default_nettype wire
